@@ rtl/stpax_pkg.sv @@
// ----------------------------------------------------------------------------
// stpax_pkg
// Shared types and constants for the stepper axis move controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stpax_pkg;

    // Fixed register field widths
    localparam int HALF_BITS    = 16;
    localparam int BACKOFF_BITS = 9;

    // APB address width and register index width
    localparam int ADDR_BITS    = 4;
    localparam int REG_IDX_BITS = 2;

    // Register reset values
    localparam logic [HALF_BITS-1:0]    HALF_PERIOD_RESET = 16'd500;
    localparam logic [BACKOFF_BITS-1:0] BACKOFF_RESET     = 9'd300;

    // Register map (index = paddr[3:2])
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_HALF_PERIOD = 2'd0,
        REG_BACKOFF     = 2'd1,
        REG_MIN_POS     = 2'd2,
        REG_MAX_POS     = 2'd3
    } reg_idx_t;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_MOVE_HIGH = 3'd1,
        PH_MOVE_LOW  = 3'd2,
        PH_BACK_HIGH = 3'd3,
        PH_BACK_LOW  = 3'd4
    } phase_t;

    // Per-item status flags from the sequencer
    typedef struct packed {
        logic step_pulse;
        logic direction_up;
        logic busy;
        logic move_done;
        logic limit_hit;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/stepper_axis_move_with_limit_backoff_core.sv @@
// ----------------------------------------------------------------------------
// stepper_axis_move_with_limit_backoff_core
// One step/direction stepper axis with limit-switch backoff.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: a tick
//   (command = 0) or a move start (command = 1) with positions and the two
//   limit switch levels. Each item yields exactly one result transfer on the
//   output channel (out_valid/out_ready) with the step, direction and enable
//   levels, busy, move_done, limit_hit and the reported position.
//   The result of an item accepted at one edge is shown from the next
//   cycle. Throughput is one item per cycle while out_ready stays high; the
//   state update for an item is a single pass through the sequencer logic
//   into the state and result registers.
//   When the receiver stalls, the result register holds and in_ready drops
//   until the result is taken; in_ready stays high while out_ready is high.
//   Reset clears the sequencer to idle and the registers to their defaults
//   (half period 500, backoff 300, min 0, max all ones); no result pending.
//   The user must write the APB port only while the axis is idle (not enforced).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stepper_axis_move_with_limit_backoff_core #(
    parameter int POSITION_BITS = 16,
    parameter int TIMER_BITS    = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // APB configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [stpax_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    // Input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            command,
    input  wire logic [POSITION_BITS-1:0]        current_position,
    input  wire logic [POSITION_BITS-1:0]        target_position,
    input  wire logic                            min_end_switch,
    input  wire logic                            max_end_switch,
    // Output channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 step_pulse,
    output logic                                 direction_up,
    output logic                                 driver_enable,
    output logic                                 busy_res,
    output logic                                 move_done,
    output logic                                 limit_hit,
    output logic [POSITION_BITS-1:0]             final_position
);
    import stpax_pkg::*;

    logic [HALF_BITS-1:0]     half_period_ticks;
    logic [BACKOFF_BITS-1:0]  backoff_steps;
    logic [POSITION_BITS-1:0] min_position;
    logic [POSITION_BITS-1:0] max_position;

    result_t                  seq_res;
    logic [POSITION_BITS-1:0] seq_final_pos;

    logic                     in_xfer;
    logic                     out_valid_reg;
    result_t                  res_reg;
    logic [POSITION_BITS-1:0] final_pos_reg;

    stpax_cfg_regs #(
        .POSITION_BITS (POSITION_BITS)
    ) u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .half_period_ticks (half_period_ticks),
        .backoff_steps     (backoff_steps),
        .min_position      (min_position),
        .max_position      (max_position)
    );

    stpax_seq #(
        .POSITION_BITS (POSITION_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (in_xfer),
        .command           (command),
        .current_position  (current_position),
        .target_position   (target_position),
        .min_end_switch    (min_end_switch),
        .max_end_switch    (max_end_switch),
        .half_period_ticks (half_period_ticks),
        .backoff_steps     (backoff_steps),
        .min_position      (min_position),
        .max_position      (max_position),
        .res               (seq_res),
        .final_position    (seq_final_pos)
    );

    // Handshake: take a new item whenever the result slot frees this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_reg       <= seq_res;
            final_pos_reg <= seq_final_pos;
        end
    end

    assign out_valid      = out_valid_reg;
    assign step_pulse     = res_reg.step_pulse;
    assign direction_up   = res_reg.direction_up;
    assign driver_enable  = res_reg.busy;
    assign busy_res       = res_reg.busy;
    assign move_done      = res_reg.move_done;
    assign limit_hit      = res_reg.limit_hit;
    assign final_position = final_pos_reg;

`ifndef SYNTHESIS
    // Every accepted item leaves a result pending in the next cycle
    a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

    // limit_hit only comes with move_done
    a_limit_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && limit_hit |-> move_done)
        else $error("limit_hit without move_done");

    // The item that ends a move leaves the axis idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_done |-> !busy_res && !step_pulse)
        else $error("move_done while still busy");

    // A step pulse is only driven during a move or backoff
    a_pulse_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_pulse |-> busy_res && driver_enable)
        else $error("step pulse while idle");
`endif

endmodule

`default_nettype wire

@@ rtl/stpax_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// stpax_cfg_regs
// APB register block: half period, backoff count and limit positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stpax_cfg_regs #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [stpax_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    output logic [stpax_pkg::HALF_BITS-1:0]      half_period_ticks,
    output logic [stpax_pkg::BACKOFF_BITS-1:0]   backoff_steps,
    output logic [POSITION_BITS-1:0]             min_position,
    output logic [POSITION_BITS-1:0]             max_position
);
    import stpax_pkg::*;

    logic [HALF_BITS-1:0]     half_reg;
    logic [BACKOFF_BITS-1:0]  backoff_reg;
    logic [POSITION_BITS-1:0] min_pos_reg;
    logic [POSITION_BITS-1:0] max_pos_reg;
    logic                     wr_en;
    reg_idx_t                 reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);

    // Register writes on the APB access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= HALF_PERIOD_RESET;
            backoff_reg <= BACKOFF_RESET;
            min_pos_reg <= '0;
            max_pos_reg <= '1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_HALF_PERIOD: half_reg    <= pwdata[HALF_BITS-1:0];
                REG_BACKOFF:     backoff_reg <= pwdata[BACKOFF_BITS-1:0];
                REG_MIN_POS:     min_pos_reg <= pwdata[POSITION_BITS-1:0];
                REG_MAX_POS:     max_pos_reg <= pwdata[POSITION_BITS-1:0];
                default:         half_reg    <= half_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_HALF_PERIOD: prdata = 32'(half_reg);
            REG_BACKOFF:     prdata = 32'(backoff_reg);
            REG_MIN_POS:     prdata = 32'(min_pos_reg);
            REG_MAX_POS:     prdata = 32'(max_pos_reg);
            default:         prdata = '0;
        endcase
    end

    assign half_period_ticks = half_reg;
    assign backoff_steps     = backoff_reg;
    assign min_position      = min_pos_reg;
    assign max_position      = max_pos_reg;

endmodule

`default_nettype wire

@@ rtl/stpax_seq.sv @@
// ----------------------------------------------------------------------------
// stpax_seq
// Move/backoff sequencer: state registers and combinational next-state logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stpax_seq #(
    parameter int POSITION_BITS = 16,
    parameter int TIMER_BITS    = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic                          command,
    input  wire logic [POSITION_BITS-1:0]      current_position,
    input  wire logic [POSITION_BITS-1:0]      target_position,
    input  wire logic                          min_end_switch,
    input  wire logic                          max_end_switch,
    input  wire logic [stpax_pkg::HALF_BITS-1:0]    half_period_ticks,
    input  wire logic [stpax_pkg::BACKOFF_BITS-1:0] backoff_steps,
    input  wire logic [POSITION_BITS-1:0]      min_position,
    input  wire logic [POSITION_BITS-1:0]      max_position,
    output stpax_pkg::result_t                 res,
    output logic [POSITION_BITS-1:0]           final_position
);
    import stpax_pkg::*;

    localparam int EXT_BITS = (TIMER_BITS > HALF_BITS) ? TIMER_BITS : HALF_BITS;

    phase_t                   phase_reg, phase_next;
    logic [POSITION_BITS-1:0] steps_reg, steps_next;
    logic [BACKOFF_BITS-1:0]  backoff_reg, backoff_next;
    logic [TIMER_BITS-1:0]    timer_reg, timer_next;
    logic                     up_reg, up_next;
    logic [POSITION_BITS-1:0] saved_reg, saved_next;

    logic [EXT_BITS-1:0]      half_ext;
    logic [TIMER_BITS-1:0]    half_trunc;
    logic [TIMER_BITS-1:0]    reload;

    // Half-period reload value; zero is treated as one
    assign half_ext   = EXT_BITS'(half_period_ticks);
    assign half_trunc = half_ext[TIMER_BITS-1:0];
    assign reload     = (half_trunc == '0) ? '0 : half_trunc - 1'b1;

    // Next state
    always_comb
    begin
        logic boundary;
        logic done;
        logic limit;

        phase_next   = phase_reg;
        steps_next   = steps_reg;
        backoff_next = backoff_reg;
        timer_next   = timer_reg;
        up_next      = up_reg;
        saved_next   = saved_reg;
        boundary     = 1'b0;
        done         = 1'b0;
        limit        = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (command)
                begin
                    saved_next = target_position;
                    if (current_position == target_position)
                    begin
                        timer_next = '0;
                        done       = 1'b1;
                    end
                    else
                    begin
                        up_next    = target_position > current_position;
                        steps_next = up_next ? target_position - current_position
                                             : current_position - target_position;
                        boundary   = 1'b1;
                    end
                end
            end
            PH_MOVE_HIGH:
            begin
                if (timer_reg != '0)
                    timer_next = timer_reg - 1'b1;
                else
                begin
                    phase_next = PH_MOVE_LOW;
                    timer_next = reload;
                end
            end
            PH_BACK_HIGH:
            begin
                if (timer_reg != '0)
                    timer_next = timer_reg - 1'b1;
                else
                begin
                    phase_next = PH_BACK_LOW;
                    timer_next = reload;
                end
            end
            PH_MOVE_LOW:
            begin
                if (timer_reg != '0)
                    timer_next = timer_reg - 1'b1;
                else
                begin
                    steps_next = steps_reg - 1'b1;
                    if (steps_next == '0)
                    begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        done       = 1'b1;
                    end
                    else
                        boundary = 1'b1;
                end
            end
            PH_BACK_LOW:
            begin
                if (timer_reg != '0)
                    timer_next = timer_reg - 1'b1;
                else
                begin
                    backoff_next = backoff_reg - 1'b1;
                    if (backoff_next == '0)
                    begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        done       = 1'b1;
                        limit      = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BACK_HIGH;
                        timer_next = reload;
                    end
                end
            end
            default:
            begin
                if (timer_reg != '0)
                    timer_next = timer_reg - 1'b1;
                else
                begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                    done       = 1'b1;
                end
            end
        endcase

        // Limit check before each step; min-end switch has priority
        if (boundary)
        begin
            if (min_end_switch || max_end_switch)
            begin
                saved_next   = up_next ? max_position : min_position;
                up_next      = min_end_switch;
                backoff_next = backoff_steps;
                if (backoff_steps == '0)
                begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                    done       = 1'b1;
                    limit      = 1'b1;
                end
                else
                begin
                    phase_next = PH_BACK_HIGH;
                    timer_next = reload;
                end
            end
            else
            begin
                phase_next = PH_MOVE_HIGH;
                timer_next = reload;
            end
        end

        res.step_pulse   = (phase_next == PH_MOVE_HIGH) || (phase_next == PH_BACK_HIGH);
        res.direction_up = up_next;
        res.busy         = phase_next != PH_IDLE;
        res.move_done    = done;
        res.limit_hit    = limit;
    end

    assign final_position = saved_next;

    // State registers, updated once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            steps_reg   <= '0;
            backoff_reg <= '0;
            timer_reg   <= '0;
            up_reg      <= 1'b0;
            saved_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            steps_reg   <= steps_next;
            backoff_reg <= backoff_next;
            timer_reg   <= timer_next;
            up_reg      <= up_next;
            saved_reg   <= saved_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stepper axis move controller. An in-bench
// model of the step sequencer predicts every result transfer; a checker
// compares each accepted result field by field against the oldest
// prediction. Directed moves cover zero-length moves, trips on either
// switch, zero backoff, starts while busy and the half-period extremes.
// Random moves then run under sender and receiver stalls, then with none.
// ----------------------------------------------------------------------------

module tb;
    import stpax_pkg::*;

    localparam int     POS_W       = 16;
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int     REPORT_MAX  = 10;

    typedef struct {
        logic             step;
        logic             dir_up;
        logic             enable;
        logic             busy;
        logic             done;
        logic             limit;
        logic [POS_W-1:0] pos;
    } axis_status_t;

    // Block ports
    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid         = 1'b0;
    logic                 in_ready;
    logic                 command          = 1'b0;
    logic [POS_W-1:0]     current_position = '0;
    logic [POS_W-1:0]     target_position  = '0;
    logic                 min_end_switch   = 1'b0;
    logic                 max_end_switch   = 1'b0;
    logic                 out_valid;
    logic                 out_ready        = 1'b0;
    logic                 step_pulse;
    logic                 direction_up;
    logic                 driver_enable;
    logic                 busy_res;
    logic                 move_done;
    logic                 limit_hit;
    logic [POS_W-1:0]     final_position;

    // Sequencer model state and its copy of the registers
    phase_t           ax_phase;
    logic [POS_W-1:0] steps_left;
    logic [8:0]       backoff_left;
    logic [15:0]      tick_cnt;
    logic             moving_up;
    logic [POS_W-1:0] report_pos;
    logic             done_now;
    logic             limit_now;
    logic [15:0]      cfg_half;
    logic [8:0]       cfg_backoff;
    logic [POS_W-1:0] cfg_min;
    logic [POS_W-1:0] cfg_max;

    axis_status_t     expected_status_q[$];
    axis_status_t     exp_status;
    int unsigned      mismatch_count = 0;
    int unsigned      active_items   = 0;
    longint           cycle_count    = 0;
    int unsigned      send_idle_pct  = 20;
    int unsigned      recv_idle_pct  = 62;

    stepper_axis_move_with_limit_backoff_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .current_position (current_position),
        .target_position  (target_position),
        .min_end_switch   (min_end_switch),
        .max_end_switch   (max_end_switch),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .step_pulse       (step_pulse),
        .direction_up     (direction_up),
        .driver_enable    (driver_enable),
        .busy_res         (busy_res),
        .move_done        (move_done),
        .limit_hit        (limit_hit),
        .final_position   (final_position)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------

    // A zero half period behaves as one tick
    function automatic logic [15:0] half_reload();
        return (cfg_half == 16'd0) ? 16'd0 : cfg_half - 16'd1;
    endfunction

    function automatic void end_move(input logic by_limit);
        ax_phase  = PH_IDLE;
        tick_cnt  = '0;
        done_now  = 1'b1;
        limit_now = by_limit;
    endfunction

    // Report position is latched from the direction of travel at the trip
    function automatic void trip_limit(input logic up);
        report_pos   = moving_up ? cfg_max : cfg_min;
        moving_up    = up;
        backoff_left = cfg_backoff;
        if (backoff_left == '0)
            end_move(1'b1);
        else
        begin
            ax_phase = PH_BACK_HIGH;
            tick_cnt = half_reload();
        end
    endfunction

    // Switches are sampled only here; min-end wins when both are pressed
    function automatic void step_boundary(input logic min_sw, input logic max_sw);
        if (min_sw)
            trip_limit(1'b1);
        else if (max_sw)
            trip_limit(1'b0);
        else
        begin
            ax_phase = PH_MOVE_HIGH;
            tick_cnt = half_reload();
        end
    endfunction

    function automatic void axis_predict(input logic cmd, input logic [POS_W-1:0] cur,
                                         input logic [POS_W-1:0] tgt,
                                         input logic min_sw, input logic max_sw);
        axis_status_t st;
        done_now  = 1'b0;
        limit_now = 1'b0;
        if (ax_phase == PH_IDLE)
        begin
            if (cmd)
            begin
                report_pos = tgt;
                if (cur == tgt)
                    end_move(1'b0);
                else
                begin
                    moving_up  = (tgt > cur);
                    steps_left = moving_up ? tgt - cur : cur - tgt;
                    step_boundary(min_sw, max_sw);
                end
            end
        end
        else if (tick_cnt != '0)
            tick_cnt = tick_cnt - 16'd1;
        else
        begin
            case (ax_phase)
                PH_MOVE_HIGH:
                begin
                    ax_phase = PH_MOVE_LOW;
                    tick_cnt = half_reload();
                end
                PH_BACK_HIGH:
                begin
                    ax_phase = PH_BACK_LOW;
                    tick_cnt = half_reload();
                end
                PH_MOVE_LOW:
                begin
                    steps_left = steps_left - 1'b1;
                    if (steps_left == '0)
                        end_move(1'b0);
                    else
                        step_boundary(min_sw, max_sw);
                end
                PH_BACK_LOW:
                begin
                    backoff_left = backoff_left - 1'b1;
                    if (backoff_left == '0)
                        end_move(1'b1);
                    else
                    begin
                        ax_phase = PH_BACK_HIGH;
                        tick_cnt = half_reload();
                    end
                end
                default:
                    end_move(1'b0);
            endcase
        end
        st.step   = (ax_phase == PH_MOVE_HIGH) || (ax_phase == PH_BACK_HIGH);
        st.dir_up = moving_up;
        st.enable = (ax_phase != PH_IDLE);
        st.busy   = (ax_phase != PH_IDLE);
        st.done   = done_now;
        st.limit  = limit_now;
        st.pos    = report_pos;
        expected_status_q.push_back(st);
    endfunction

    // ------------------------------------------------------------------------
    // Bus helpers
    // ------------------------------------------------------------------------

    // One input transfer, with an optional random gap before it
    task automatic send_item(input logic cmd, input logic [POS_W-1:0] cur,
                             input logic [POS_W-1:0] tgt,
                             input logic min_sw, input logic max_sw);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid         <= 1'b1;
        command          <= cmd;
        current_position <= cur;
        target_position  <= tgt;
        min_end_switch   <= min_sw;
        max_end_switch   <= max_sw;
        do
            @(posedge clk);
        while (!in_ready);
        // ticks while idle do nothing and are not counted
        if (ax_phase != PH_IDLE || cmd)
            active_items++;
        axis_predict(cmd, cur, tgt, min_sw, max_sw);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_status_q.size() != 0);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_HALF_PERIOD: cfg_half    = value[15:0];
            REG_BACKOFF:     cfg_backoff = value[8:0];
            REG_MIN_POS:     cfg_min     = value[POS_W-1:0];
            REG_MAX_POS:     cfg_max     = value[POS_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only with the axis idle and no result in flight
    task automatic configure_axis(input logic [15:0] half, input logic [8:0] backoff,
                                  input logic [POS_W-1:0] min_pos,
                                  input logic [POS_W-1:0] max_pos);
        wait_results_drained();
        apb_write(REG_HALF_PERIOD, 32'(half));
        apb_write(REG_BACKOFF, 32'(backoff));
        apb_write(REG_MIN_POS, 32'(min_pos));
        apb_write(REG_MAX_POS, 32'(max_pos));
    endtask

    // Tick until the move ends; switches and busy restarts at given rates
    task automatic finish_move(input int unsigned min_pct, input int unsigned max_pct,
                               input int unsigned restart_pct);
        while (ax_phase != PH_IDLE)
            send_item($urandom_range(99) < restart_pct, 16'($urandom), 16'($urandom),
                      $urandom_range(99) < min_pct, $urandom_range(99) < max_pct);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_reset_and_zero_length();
        send_item(1'b0, 16'h5A5A, 16'hA5A5, 1'b1, 1'b1);
        send_item(1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_item(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_item(1'b1, 16'h8001, 16'h8001, 1'b0, 1'b1);
    endtask

    task automatic test_plain_moves();
        configure_axis(16'd1, 9'd2, 16'h00A5, 16'hFF5A);
        send_item(1'b1, 16'd10, 16'd13, 1'b0, 1'b0);
        finish_move(0, 0, 0);
        send_item(1'b1, 16'hFFFF, 16'hFFFD, 1'b0, 1'b0);
        finish_move(0, 0, 0);
    endtask

    task automatic test_limit_trips();
        // trips on the start transfer, both directions
        send_item(1'b1, 16'd100, 16'd103, 1'b1, 1'b0);
        finish_move(0, 0, 0);
        send_item(1'b1, 16'd200, 16'd197, 1'b0, 1'b1);
        finish_move(0, 0, 0);
        // trips at a later step boundary
        send_item(1'b1, 16'd300, 16'd304, 1'b0, 1'b0);
        finish_move(0, 100, 0);
        send_item(1'b1, 16'd400, 16'd396, 1'b0, 1'b0);
        finish_move(100, 0, 0);
        // both switches pressed
        send_item(1'b1, 16'd500, 16'd495, 1'b1, 1'b1);
        finish_move(0, 0, 0);
        // full-range moves cut short by a switch
        send_item(1'b1, 16'h0000, 16'hFFFF, 1'b0, 1'b1);
        finish_move(0, 0, 0);
        send_item(1'b1, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
        finish_move(0, 0, 0);
        // zero backoff ends the move on the tripping transfer
        configure_axis(16'd1, 9'd0, 16'h3C3C, 16'hC3C3);
        send_item(1'b1, 16'd20, 16'd25, 1'b0, 1'b1);
        send_item(1'b1, 16'd30, 16'd27, 1'b0, 1'b0);
        finish_move(100, 100, 0);
    endtask

    task automatic test_start_while_busy();
        configure_axis(16'd2, 9'd1, 16'h0F0F, 16'hF0F0);
        send_item(1'b1, 16'd1000, 16'd1003, 1'b0, 1'b0);
        finish_move(0, 0, 100);
        send_item(1'b1, 16'd2000, 16'd1996, 1'b0, 1'b0);
        finish_move(10, 10, 50);
    endtask

    task automatic test_half_period_extremes();
        configure_axis(16'd0, 9'd511, 16'h0000, 16'hFFFF);
        send_item(1'b1, 16'd7, 16'd9, 1'b0, 1'b0);
        finish_move(0, 0, 0);
        send_item(1'b1, 16'd9, 16'd7, 1'b0, 1'b1);
        finish_move(0, 0, 0);
    endtask

    // Slow pulse: many ticks in each half of a single step
    task automatic test_long_half_period();
        configure_axis(16'd64, 9'd1, 16'h1111, 16'hEEEE);
        send_item(1'b1, 16'd40000, 16'd40001, 1'b0, 1'b0);
        finish_move(0, 0, 0);
    endtask

    task automatic test_random_moves(input int unsigned n_items);
        int unsigned      stop_at = active_items + n_items;
        int unsigned      moves   = 0;
        int unsigned      delta;
        logic [POS_W-1:0] cur;
        logic [POS_W-1:0] tgt;
        logic             min_sw;
        logic             max_sw;
        while (active_items < stop_at)
        begin
            // new register settings every few moves
            if (moves % 8 == 0)
                configure_axis(16'($urandom_range(3)),
                               ($urandom_range(7) == 0) ? 9'($urandom_range(24, 8))
                                                        : 9'($urandom_range(4)),
                               16'($urandom), 16'($urandom));
            moves++;
            cur = 16'($urandom);
            if ($urandom_range(9) == 0)
            begin
                // long move: force a trip at the start to keep it short
                tgt    = 16'($urandom);
                min_sw = 1'($urandom_range(1));
                max_sw = !min_sw || ($urandom_range(1) == 1);
            end
            else
            begin
                delta = $urandom_range(6);
                if ($urandom_range(1) == 1)
                    tgt = (cur > 16'hFFFF - delta) ? 16'(cur - delta) : 16'(cur + delta);
                else
                    tgt = (cur < delta) ? 16'(cur + delta) : 16'(cur - delta);
                min_sw = ($urandom_range(99) < 8);
                max_sw = ($urandom_range(99) < 8);
            end
            // occasional idle tick ahead of the start
            if ($urandom_range(9) == 0)
                send_item(1'b0, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
            send_item(1'b1, cur, tgt, min_sw, max_sw);
            finish_move(8, 8, 6);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    function automatic void check_field(input string fname, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t: %s expected %0h got %0h", $realtime, fname, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: result transfer with nothing predicted", $realtime);
            end
            else
            begin
                exp_status = expected_status_q.pop_front();
                check_field("step_pulse", exp_status.step, step_pulse);
                check_field("direction_up", exp_status.dir_up, direction_up);
                check_field("driver_enable", exp_status.enable, driver_enable);
                check_field("busy_res", exp_status.busy, busy_res);
                check_field("move_done", exp_status.done, move_done);
                check_field("limit_hit", exp_status.limit, limit_hit);
                check_field("final_position", exp_status.pos, final_position);
            end
        end
    end

    // Receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        ax_phase     = PH_IDLE;
        steps_left   = '0;
        backoff_left = '0;
        tick_cnt     = '0;
        moving_up    = 1'b0;
        report_pos   = '0;
        done_now     = 1'b0;
        limit_now    = 1'b0;
        cfg_half     = HALF_PERIOD_RESET;
        cfg_backoff  = BACKOFF_RESET;
        cfg_min      = '0;
        cfg_max      = '1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        test_reset_and_zero_length();
        test_plain_moves();
        test_limit_trips();
        test_start_while_busy();
        test_half_period_extremes();
        test_random_moves(200);

        // sender idles heavily, receiver lightly
        wait_results_drained();
        send_idle_pct = 62;
        recv_idle_pct = 20;
        test_random_moves(200);

        // no idling on either side
        wait_results_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_long_half_period();
        test_random_moves(150);

        wait_results_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && expected_status_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ stepper_axis_move_with_limit_backoff_core.f @@
rtl/stpax_pkg.sv
rtl/stpax_cfg_regs.sv
rtl/stpax_seq.sv
rtl/stepper_axis_move_with_limit_backoff_core.sv
tb/tb.sv
